>>> rtl/growable_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// growable_slot_allocator_assert
// assertion macros for the slot allocator checker
// ----------------------------------------------------------------------------
`ifndef GROWABLE_SLOT_ALLOCATOR_ASSERT_SVH
`define GROWABLE_SLOT_ALLOCATOR_ASSERT_SVH

// clocked assertion, off while reset is held
`define GSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define GSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// types and constants of the growable slot allocator
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int MaxSlots = 64;
  localparam int SlotW    = 6;
  localparam int CountW   = 7;
  localparam int FuncW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  typedef logic [MaxSlots-1:0] flags_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [CountW-1:0]   count_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_RELEASE = 3'd1,
    FUNC_QUERY   = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_INIT    = 3'd4
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INITIAL_SLOTS = 2'd0,
    CFG_SLOT_LIMIT    = 2'd1
  } cfg_idx_e;

  localparam count_t InitialSlotsRst = 7'd1;
  localparam count_t SlotLimitRst    = 7'd64;
  localparam count_t MaxSlotsCnt     = 7'(MaxSlots);

endpackage

>>> rtl/growable_slot_allocator.sv
// ----------------------------------------------------------------------------
// growable_slot_allocator
// slot pool with one active flag per slot and a count that grows to a limit
// ----------------------------------------------------------------------------
// The block takes one operation word per clock while the input is not
// stalled and returns one result word per operation: the word waits in the
// input register, then a single pass finds the lowest free slot, updates the
// flag vector, slot count and active count, and loads the result register.
// Back pressure on the result side holds the input register and then stalls
// the input. The flags are flip-flops cleared directly by reset, so the block
// is ready at once after reset; configuration writes are taken in any cycle.
module growable_slot_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // operation words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gsa_pkg::FuncW-1:0]    func_i,
  input  logic [gsa_pkg::SlotW-1:0]    slot_id_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         granted_o,
  output logic [gsa_pkg::SlotW-1:0]    slot_o,
  output logic                         is_active_o,
  output logic [gsa_pkg::CountW-1:0]   free_slots_o,
  output logic                         pool_full_o,
  output logic [gsa_pkg::CountW-1:0]   slots_in_use_range_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gsa_pkg::CfgDataW-1:0] cfg_data_i
);
  import gsa_pkg::*;

  count_t initial_slots_q;
  count_t slot_limit_q;

  logic   s1_valid_q;
  func_e  func_q;
  slot_t  id_q;

  flags_t flags_q, flags_d;
  count_t cnt_q, cnt_d;
  count_t act_q, act_d;

  logic   out_valid_q;
  logic   granted_q, granted_d;
  slot_t  slot_q, slot_d;
  logic   active_q, active_d;
  count_t free_q, free_d;
  logic   full_q;
  count_t range_q;

  logic   out_ready;
  logic   fire;
  count_t lim;
  flags_t lz_oh;
  logic   lz_any;
  slot_t  lz_idx;
  logic   alloc_ok;
  logic   init_ok;
  logic   id_in_range;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_slots_q <= InitialSlotsRst;
      slot_limit_q    <= SlotLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INITIAL_SLOTS: initial_slots_q <= cfg_data_i;
        CFG_SLOT_LIMIT:    slot_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_e'(func_i);
      id_q   <= slot_id_i;
    end
  end

  // lowest inactive slot
  assign lz_oh  = ~flags_q & (flags_q + flags_t'(1));
  assign lz_any = |lz_oh;

  always_comb begin
    lz_idx = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      if (lz_oh[i]) begin
        lz_idx = lz_idx | slot_t'(i);
      end
    end
  end

  assign lim = (slot_limit_q < MaxSlotsCnt) ? slot_limit_q : MaxSlotsCnt;

  // flags above the count stay clear, so the lowest zero is either below the
  // count or the next slot to append
  assign alloc_ok = lz_any && (({1'b0, lz_idx} < cnt_q) || (cnt_q < lim));

  assign init_ok = (initial_slots_q != '0) && (slot_limit_q != '0) &&
                   (initial_slots_q <= slot_limit_q) &&
                   (initial_slots_q <= MaxSlotsCnt);

  assign id_in_range = {1'b0, id_q} < cnt_q;

  always_comb begin
    flags_d   = flags_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    granted_d = 1'b0;
    slot_d    = '0;
    active_d  = 1'b0;
    case (func_q)
      FUNC_ALLOC: begin
        if (alloc_ok) begin
          flags_d   = flags_q | lz_oh;
          act_d     = act_q + count_t'(1);
          granted_d = 1'b1;
          slot_d    = lz_idx;
          if ({1'b0, lz_idx} >= cnt_q) begin
            cnt_d = cnt_q + count_t'(1);
          end
        end
      end
      FUNC_RELEASE: begin
        if (id_in_range && flags_q[id_q]) begin
          flags_d[id_q] = 1'b0;
          act_d         = act_q - count_t'(1);
        end
      end
      FUNC_QUERY: begin
        active_d = id_in_range && flags_q[id_q];
      end
      FUNC_CLEAR: begin
        flags_d = '0;
        act_d   = '0;
      end
      FUNC_INIT: begin
        if (init_ok) begin
          flags_d = '0;
          act_d   = '0;
          cnt_d   = initial_slots_q;
        end
      end
      default: ;
    endcase
    free_d = cnt_d - act_d;
  end

  // pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      cnt_q   <= count_t'(1);
      act_q   <= '0;
    end else if (fire) begin
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      granted_q <= granted_d;
      slot_q    <= slot_d;
      active_q  <= active_d;
      free_q    <= free_d;
      full_q    <= (free_d == '0);
      range_q   <= cnt_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign granted_o            = granted_q;
  assign slot_o               = slot_q;
  assign is_active_o          = active_q;
  assign free_slots_o         = free_q;
  assign pool_full_o          = full_q;
  assign slots_in_use_range_o = range_q;

endmodule

>>> rtl/gsa_checker.sv
// ----------------------------------------------------------------------------
// gsa_checker
// port level checks of the growable slot allocator
// ----------------------------------------------------------------------------
`include "growable_slot_allocator_assert.svh"

module gsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [gsa_pkg::FuncW-1:0]    func_i,
  input logic [gsa_pkg::SlotW-1:0]    slot_id_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         granted_o,
  input logic [gsa_pkg::SlotW-1:0]    slot_o,
  input logic                         is_active_o,
  input logic [gsa_pkg::CountW-1:0]   free_slots_o,
  input logic                         pool_full_o,
  input logic [gsa_pkg::CountW-1:0]   slots_in_use_range_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [gsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [gsa_pkg::CfgDataW-1:0] cfg_data_i
);
  import gsa_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_valid_i, in_stall_o, func_i, slot_id_i, is_active_o,
                       cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

  `GSA_ASSERT(a_full_matches_free,
    out_valid_o |-> (pool_full_o == (free_slots_o == '0)),
    "full flag disagrees with free count")

  `GSA_ASSERT(a_free_within_count,
    out_valid_o |-> (free_slots_o <= slots_in_use_range_o),
    "free count above slot count")

  `GSA_ASSERT(a_grant_in_range,
    out_valid_o |-> (granted_o ? ({1'b0, slot_o} < slots_in_use_range_o)
                               : (slot_o == '0)),
    "granted slot outside the pool or slot set without grant")

  `GSA_ASSERT(a_count_bounds,
    out_valid_o |-> ((slots_in_use_range_o != '0) &&
                     (slots_in_use_range_o <= MaxSlotsCnt)),
    "slot count out of bounds")

  `GSA_ASSERT(a_stalled_result_holds,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(slot_o) &&
                                      $stable(free_slots_o) && $stable(granted_o)),
    "stalled result word changed")

endmodule

bind growable_slot_allocator gsa_checker u_gsa_checker (.*);
